// ===== rtl/ksm_pkg.sv =====
// ----------------------------------------------------------------------------
// ksm_pkg
// Shared codes and controller/datapath interface types for the k-way merge.
// ----------------------------------------------------------------------------
`default_nettype none

package ksm_pkg;

    localparam int         NUM_STREAMS = 8;

    localparam logic [1:0] FUNC_APPEND = 2'd0;
    localparam logic [1:0] FUNC_POP    = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_INACTIVE = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    localparam logic       REG_IDX_ACTIVE = 1'b0;
    localparam logic [3:0] ACTIVE_RESET   = 4'd8;

    typedef struct packed {
        logic load;
        logic exec_do;
        logic scan_issue;
        logic pop_commit;
    } ksm_cmd_t;

    typedef struct packed {
        logic in_pop;
        logic scan_last;
        logic out_free;
    } ksm_sts_t;

endpackage

`default_nettype wire

// ===== rtl/ksm_ctrl.sv =====
// ----------------------------------------------------------------------------
// ksm_ctrl
// Sequencer: accepts a request, runs the head scan for pops, commits results.
// ----------------------------------------------------------------------------
`default_nettype none

module ksm_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  ksm_pkg::ksm_sts_t      sts,
    output ksm_pkg::ksm_cmd_t      cmd
);
    import ksm_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_TAIL = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = sts.in_pop ? S_SCAN : S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (sts.out_free)
                begin
                    cmd.exec_do = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_SCAN:
            begin
                cmd.scan_issue = 1'b1;
                if (sts.scan_last)
                    state_next = S_TAIL;
            end
            S_TAIL:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.pop_commit = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

// ===== rtl/ksm_datapath.sv =====
// ----------------------------------------------------------------------------
// ksm_datapath
// Stream key memory, per-stream fill and read counters, head compare and
// the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ksm_datapath #(
    parameter int STREAM_DEPTH = 256
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  ksm_pkg::ksm_cmd_t      cmd,
    output ksm_pkg::ksm_sts_t      sts,
    input  wire logic [3:0]        active_cfg,
    input  wire logic [1:0]        func,
    input  wire logic [2:0]        stream_id,
    input  wire logic signed [31:0] key_value,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [1:0]             status,
    output logic signed [31:0]     merged_key,
    output logic [2:0]             source_stream,
    output logic                   is_last
);
    import ksm_pkg::*;

    localparam int SW   = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
    localparam int PW   = (STREAM_DEPTH > 1) ? $clog2(STREAM_DEPTH) : 1;
    localparam int CW   = $clog2(STREAM_DEPTH + 1);
    localparam int NB   = $clog2(NUM_STREAMS + 1);
    localparam int AW   = (NB > 4) ? NB : 4;
    localparam int MEMD = NUM_STREAMS << PW;

    logic [31:0]    mem [MEMD];
    logic [31:0]    rdata_reg;

    logic [CW-1:0]  fill_reg [NUM_STREAMS];
    logic [CW-1:0]  rp_reg   [NUM_STREAMS];

    logic [1:0]     func_reg;
    logic [2:0]     sid_reg;
    logic [31:0]    key_reg;

    logic [SW-1:0]  idx_reg;
    logic           v1_reg;
    logic [SW-1:0]  i1_reg;
    logic           m1_reg;

    logic           found_reg;
    logic           multi_reg;
    logic [SW-1:0]  best_reg;
    logic [31:0]    best_key_reg;
    logic           best_more_reg;

    logic           out_valid_reg;
    logic [1:0]     status_reg;
    logic [31:0]    merged_key_reg;
    logic [2:0]     source_stream_reg;
    logic           is_last_reg;

    logic [AW-1:0]  act_eff;
    logic [SW-1:0]  sid_idx;
    logic           sid_active;
    logic           sid_full;
    logic           append_ok;
    logic [CW-1:0]  scan_rp;
    logic [CW-1:0]  scan_fill;
    logic           scan_nonempty;
    logic           scan_more;
    logic [AW:0]    idx_next_ext;
    logic           take;

    always_comb
    begin
        act_eff = (AW'(active_cfg) > AW'(NUM_STREAMS)) ? AW'(NUM_STREAMS) : AW'(active_cfg);
        sid_idx    = SW'(sid_reg);
        sid_active = (AW'(sid_reg) < act_eff);
        sid_full   = (fill_reg[sid_idx] == CW'(STREAM_DEPTH));
        append_ok  = (func_reg == FUNC_APPEND) && sid_active && !sid_full;

        scan_rp       = rp_reg[idx_reg];
        scan_fill     = fill_reg[idx_reg];
        scan_nonempty = (AW'(idx_reg) < act_eff) && (scan_rp < scan_fill);
        scan_more     = ((CW + 1)'(scan_rp) + 1'b1) < (CW + 1)'(scan_fill);
        idx_next_ext  = (AW + 1)'(idx_reg) + 1'b1;

        take = v1_reg && (!found_reg || ($signed(rdata_reg) < $signed(best_key_reg)));

        sts.in_pop    = (func == FUNC_POP);
        sts.scan_last = (idx_next_ext >= {1'b0, act_eff});
        sts.out_free  = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec_do && append_ok)
            mem[{sid_idx, PW'(fill_reg[sid_idx])}] <= key_reg;
        rdata_reg <= mem[{idx_reg, PW'(scan_rp)}];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= func;
            sid_reg  <= stream_id;
            key_reg  <= key_value;
        end
        i1_reg <= idx_reg;
        m1_reg <= scan_more;
        if (take)
        begin
            best_reg      <= i1_reg;
            best_key_reg  <= rdata_reg;
            best_more_reg <= m1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_STREAMS; i++)
            begin
                fill_reg[i] <= '0;
                rp_reg[i]   <= '0;
            end
        end
        else if (cmd.exec_do && (func_reg == FUNC_CLEAR))
        begin
            for (int i = 0; i < NUM_STREAMS; i++)
            begin
                fill_reg[i] <= '0;
                rp_reg[i]   <= '0;
            end
        end
        else
        begin
            if (cmd.exec_do && append_ok)
                fill_reg[sid_idx] <= fill_reg[sid_idx] + 1'b1;
            if (cmd.pop_commit && found_reg)
                rp_reg[best_reg] <= rp_reg[best_reg] + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            v1_reg    <= 1'b0;
            found_reg <= 1'b0;
            multi_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            idx_reg   <= '0;
            v1_reg    <= 1'b0;
            found_reg <= 1'b0;
            multi_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.scan_issue && scan_nonempty;
            if (cmd.scan_issue)
                idx_reg <= idx_reg + 1'b1;
            if (v1_reg)
            begin
                found_reg <= 1'b1;
                if (found_reg)
                    multi_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.exec_do || cmd.pop_commit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec_do)
        begin
            merged_key_reg    <= '0;
            source_stream_reg <= '0;
            is_last_reg       <= 1'b0;
            if (func_reg == FUNC_APPEND && !sid_active)
                status_reg <= ST_INACTIVE;
            else if (func_reg == FUNC_APPEND && sid_full)
                status_reg <= ST_FULL;
            else
                status_reg <= ST_OK;
        end
        else if (cmd.pop_commit)
        begin
            if (found_reg)
            begin
                status_reg        <= ST_OK;
                merged_key_reg    <= best_key_reg;
                source_stream_reg <= 3'(best_reg);
                is_last_reg       <= !(multi_reg || best_more_reg);
            end
            else
            begin
                status_reg        <= ST_EMPTY;
                merged_key_reg    <= '0;
                source_stream_reg <= '0;
                is_last_reg       <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign merged_key    = merged_key_reg;
    assign source_stream = source_stream_reg;
    assign is_last       = is_last_reg;

endmodule

`default_nettype wire

// ===== rtl/kway_sorted_stream_merge_core.sv =====
// ----------------------------------------------------------------------------
// kway_sorted_stream_merge_core
// K-way merge of signed 32-bit key streams with an APB configuration port.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries one request: func, stream_id and
// key_value. Append stores key_value at the tail of stream stream_id, pop
// returns the smallest head key over the active streams (ties go to the lower
// stream), clear empties every stream. Each request yields exactly one result
// on the output channel (out_valid/out_ready): status, merged_key,
// source_stream and is_last.
// Requests are handled one at a time: append, clear and unknown codes go from
// acceptance to an execute step; a pop runs the head scan over the effective
// active stream count (at least one head is scanned), which reads one stream
// head per cycle from the key memory, then a tail step and a result step.
// The next request is accepted only after the current result is committed.
// The output register holds a result while the receiver stalls; the block
// accepts one more request, runs it up to its result step and holds there
// with in_ready low until the result is taken. Reset empties all streams and
// sets active_streams to 8; key memory contents are left as they are.
// Register active_streams lies at byte address 0 and is to be written by the
// user only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module kway_sorted_stream_merge_core #(
    parameter int STREAM_DEPTH = 256
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         func,
    input  wire logic [2:0]         stream_id,
    input  wire logic signed [31:0] key_value,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [1:0]              status,
    output logic signed [31:0]      merged_key,
    output logic [2:0]              source_stream,
    output logic                    is_last
);
    import ksm_pkg::*;

    logic [3:0] active_reg;
    ksm_cmd_t   cmd;
    ksm_sts_t   sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            active_reg <= ACTIVE_RESET;
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_IDX_ACTIVE))
            active_reg <= pwdata[3:0];
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_IDX_ACTIVE) ? {28'd0, active_reg} : 32'd0;

    ksm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ksm_datapath #(
        .STREAM_DEPTH (STREAM_DEPTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .active_cfg    (active_reg),
        .func          (func),
        .stream_id     (stream_id),
        .key_value     (key_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .merged_key    (merged_key),
        .source_stream (source_stream),
        .is_last       (is_last)
    );

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the k-way sorted stream merge. Requests go in from
// a queue through a clocked driver with random idle bursts; a clocked monitor
// stalls the result channel at random and compares every result with the
// outcome that a local merge model worked out when the request was accepted.
// The active stream count is rewritten over APB between phases, while idle.
// ----------------------------------------------------------------------------
module tb_top;

    import ksm_pkg::*;

    localparam int         STREAM_DEPTH = 256;
    localparam int         DRAIN_CYCLES = 16;
    localparam int         STALL_LIMIT  = 4000;
    localparam logic [1:0] FUNC_NOP     = 2'd3;

    typedef struct {
        logic [1:0]         func;
        logic [2:0]         sid;
        logic signed [31:0] key;
    } merge_req_t;

    typedef struct {
        logic [1:0]         status;
        logic signed [31:0] key;
        logic [2:0]         src;
        logic               last;
    } merge_res_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = 3'd0;
    logic [31:0]        pwdata = 32'd0;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [1:0]         func = FUNC_APPEND;
    logic [2:0]         stream_id = 3'd0;
    logic signed [31:0] key_value = 32'sd0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [1:0]         status;
    logic signed [31:0] merged_key;
    logic [2:0]         source_stream;
    logic               is_last;

    merge_req_t         requests_todo[$];
    merge_res_t         outcomes_due[$];
    merge_req_t         cur_req;
    merge_res_t         want_res;
    int                 gap_left;
    int                 stall_left;
    int                 error_count = 0;
    int                 ops_queued = 0;
    bit                 calm_phase = 1'b0;

    logic [3:0]         active_cfg = ACTIVE_RESET;
    logic signed [31:0] stream_keys [NUM_STREAMS][STREAM_DEPTH];
    int                 fill_cnt [NUM_STREAMS] = '{default: 0};
    int                 rd_pos [NUM_STREAMS] = '{default: 0};

    kway_sorted_stream_merge_core #(
        .STREAM_DEPTH (STREAM_DEPTH)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .stream_id     (stream_id),
        .key_value     (key_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .merged_key    (merged_key),
        .source_stream (source_stream),
        .is_last       (is_last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic merge_res_t merge_outcome(input merge_req_t req);
        merge_res_t         res;
        int                 act;
        int                 best;
        int                 s;
        logic signed [31:0] best_key;
        bit                 found;
        bit                 more;
        res.status = ST_OK;
        res.key    = 32'sd0;
        res.src    = 3'd0;
        res.last   = 1'b0;
        act        = (int'(active_cfg) > NUM_STREAMS) ? NUM_STREAMS : int'(active_cfg);
        found      = 1'b0;
        more       = 1'b0;
        best       = 0;
        best_key   = 32'sd0;
        case (req.func)
            FUNC_APPEND:
            begin
                if (int'(req.sid) >= act)
                    res.status = ST_INACTIVE;
                else if (fill_cnt[req.sid] >= STREAM_DEPTH)
                    res.status = ST_FULL;
                else
                begin
                    stream_keys[req.sid][fill_cnt[req.sid]] = req.key;
                    fill_cnt[req.sid]++;
                end
            end
            FUNC_POP:
            begin
                for (s = 0; s < act; s++)
                begin
                    if (rd_pos[s] < fill_cnt[s] &&
                        (!found || stream_keys[s][rd_pos[s]] < best_key))
                    begin
                        found    = 1'b1;
                        best     = s;
                        best_key = stream_keys[s][rd_pos[s]];
                    end
                end
                if (!found)
                    res.status = ST_EMPTY;
                else
                begin
                    rd_pos[best]++;
                    for (s = 0; s < act; s++)
                        if (rd_pos[s] < fill_cnt[s])
                            more = 1'b1;
                    res.key  = best_key;
                    res.src  = 3'(best);
                    res.last = !more;
                end
            end
            FUNC_CLEAR:
            begin
                for (s = 0; s < NUM_STREAMS; s++)
                begin
                    fill_cnt[s] = 0;
                    rd_pos[s]   = 0;
                end
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    // Driver: hold each request until accepted, idle in random bursts.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                outcomes_due.push_back(merge_outcome(cur_req));
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (requests_todo.size() != 0)
                begin
                    if (!calm_phase && $urandom_range(0, 7) == 0)
                    begin
                        gap_left <= $urandom_range(0, 12);
                        in_valid <= 1'b0;
                    end
                    else
                    begin
                        cur_req = requests_todo.pop_front();
                        in_valid  <= 1'b1;
                        func      <= cur_req.func;
                        stream_id <= cur_req.sid;
                        key_value <= cur_req.key;
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: stall in random bursts, check each result in order.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (outcomes_due.size() == 0)
                begin
                    $error("unexpected result: status %0d merged_key %0d", status, merged_key);
                    error_count++;
                end
                else
                begin
                    want_res = outcomes_due.pop_front();
                    if (status !== want_res.status)
                    begin
                        $error("status: expected %0d, actual %0d", want_res.status, status);
                        error_count++;
                    end
                    if (merged_key !== want_res.key)
                    begin
                        $error("merged_key: expected %0d, actual %0d",
                               want_res.key, merged_key);
                        error_count++;
                    end
                    if (source_stream !== want_res.src)
                    begin
                        $error("source_stream: expected %0d, actual %0d",
                               want_res.src, source_stream);
                        error_count++;
                    end
                    if (is_last !== want_res.last)
                    begin
                        $error("is_last: expected %0d, actual %0d", want_res.last, is_last);
                        error_count++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                out_ready  <= 1'b0;
            end
            else if (!calm_phase && $urandom_range(0, 7) == 0)
            begin
                stall_left <= $urandom_range(0, 12);
                out_ready  <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("kway_sorted_stream_merge_core: mismatch");
        $finish;
    end

    function automatic logic signed [31:0] pick_key();
        case ($urandom_range(0, 9))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return 32'sd0;
            3: return -32'sd1;
            4, 5: return 32'($urandom_range(0, 7)) - 32'sd3;
            default: return $urandom;
        endcase
    endfunction

    task automatic push_req(input logic [1:0] f, input logic [2:0] s,
                            input logic signed [31:0] k);
        merge_req_t req;
        req.func = f;
        req.sid  = s;
        req.key  = k;
        requests_todo.push_back(req);
        if (f != FUNC_NOP)
            ops_queued++;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (requests_todo.size() != 0 || outcomes_due.size() != 0 || in_valid)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_active(input logic [3:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_IDX_ACTIVE, 2'b00};
        pwdata  <= {28'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        active_cfg = value;
        @(negedge clk);
    endtask

    // Sorted run per stream, then drain it with a pop or two extra.
    task automatic add_burst(input int act);
        int     n;
        int     i;
        int     sid;
        int     span;
        longint k;
        longint last_key [NUM_STREAMS];
        bit     started [NUM_STREAMS];
        n    = $urandom_range(1, 12);
        span = (act < 1) ? 1 : ((act > NUM_STREAMS) ? NUM_STREAMS : act);
        for (i = 0; i < NUM_STREAMS; i++)
            started[i] = 1'b0;
        for (i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 7) == 0)
                sid = $urandom_range(0, NUM_STREAMS - 1);
            else
                sid = $urandom_range(0, span - 1);
            if (!started[sid])
                k = longint'(pick_key());
            else if ($urandom_range(0, 3) == 0)
                k = last_key[sid];
            else
                k = last_key[sid] + longint'($urandom_range(1, 1 << 20));
            if (k > 64'sd2147483647)
                k = 64'sd2147483647;
            started[sid]  = 1'b1;
            last_key[sid] = k;
            push_req(FUNC_APPEND, 3'(sid), 32'(k));
        end
        n = n + $urandom_range(0, 2);
        for (i = 0; i < n; i++)
            push_req(FUNC_POP, 3'($urandom), $urandom);
    endtask

    task automatic add_random(input int count, input int act);
        int target;
        int i;
        int n;
        target = ops_queued + count;
        while (ops_queued < target)
        begin
            case ($urandom_range(0, 9))
                6, 7:
                begin
                    n = $urandom_range(1, 6);
                    for (i = 0; i < n; i++)
                        push_req(2'($urandom_range(0, 3)), 3'($urandom),
                                 ($urandom_range(0, 1) == 0) ? pick_key() : $urandom);
                end
                8:
                begin
                    n = $urandom_range(1, 4);
                    for (i = 0; i < n; i++)
                        push_req(FUNC_POP, 3'($urandom), $urandom);
                end
                9:
                    push_req(FUNC_CLEAR, 3'($urandom), $urandom);
                default:
                    add_burst(act);
            endcase
        end
    endtask

    initial
    begin : stimulus
        int i;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        push_req(FUNC_POP, 3'd0, 32'sd0);
        push_req(FUNC_APPEND, 3'd0, 32'sh7fff_ffff);
        push_req(FUNC_APPEND, 3'd1, 32'sh8000_0000);
        push_req(FUNC_APPEND, 3'd2, 32'sd0);
        push_req(FUNC_APPEND, 3'd3, -32'sd1);
        push_req(FUNC_APPEND, 3'd4, 32'sd5);
        push_req(FUNC_APPEND, 3'd5, 32'sd5);
        push_req(FUNC_APPEND, 3'd6, 32'sh7fff_ffff);
        push_req(FUNC_APPEND, 3'd7, 32'sh8000_0000);
        for (i = 0; i < 9; i++)
            push_req(FUNC_POP, 3'd7, -32'sd1);
        push_req(FUNC_NOP, 3'd7, 32'shffff_ffff);
        push_req(FUNC_APPEND, 3'd7, 32'sh5555_5555);
        push_req(FUNC_CLEAR, 3'd0, 32'sd0);
        push_req(FUNC_POP, 3'd0, 32'sd0);
        push_req(FUNC_APPEND, 3'd6, 32'sd10);
        push_req(FUNC_APPEND, 3'd1, 32'sd20);
        wait_idle();

        // hide streams 2..7, then bring them back
        write_active(4'd2);
        push_req(FUNC_APPEND, 3'd5, 32'sd1);
        push_req(FUNC_POP, 3'd0, 32'sd0);
        push_req(FUNC_POP, 3'd0, 32'sd0);
        wait_idle();
        write_active(4'd8);
        push_req(FUNC_POP, 3'd0, 32'sd0);
        push_req(FUNC_CLEAR, 3'd0, 32'sd0);
        wait_idle();

        write_active(4'd0);
        add_random(20, 0);
        wait_idle();

        // fill stream 0 past its depth
        write_active(4'd1);
        for (i = 0; i < STREAM_DEPTH + 2; i++)
            push_req(FUNC_APPEND, 3'd0, ($urandom_range(0, 3) == 0) ? pick_key() : $urandom);
        for (i = 0; i < 3; i++)
            push_req(FUNC_APPEND, 3'd1, $urandom);
        for (i = 0; i < 10; i++)
            push_req(FUNC_POP, 3'($urandom), $urandom);
        push_req(FUNC_CLEAR, 3'd0, 32'sd0);
        wait_idle();

        write_active(4'd15);
        add_random(250, 8);
        wait_idle();

        write_active(4'd4);
        add_random(150, 4);
        wait_idle();

        i = $urandom_range(1, 8);
        write_active(4'(i));
        add_random(150, i);
        wait_idle();

        write_active(4'd9);
        add_random(100, 8);
        wait_idle();

        write_active(4'd8);
        calm_phase = 1'b1;
        add_random(150, 8);
        wait_idle();

        if (error_count == 0)
            $display("kway_sorted_stream_merge_core: match");
        else
            $display("kway_sorted_stream_merge_core: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/ksm_pkg.sv
rtl/ksm_ctrl.sv
rtl/ksm_datapath.sv
rtl/kway_sorted_stream_merge_core.sv
tb/tb_top.sv
